// ===== hdl/kwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kerned text width measure: shared definitions
// Table sizes, command codes, register indexes, memory entry layouts, state
// encodings and the saturating width accumulator.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned GLYPH_CODES = 256;
  localparam int unsigned KERN_PAIRS  = 256;

  localparam int unsigned GLYPH_AW = (GLYPH_CODES > 1) ? $clog2(GLYPH_CODES) : 1;
  localparam int unsigned PAIR_AW  = (KERN_PAIRS > 1) ? $clog2(KERN_PAIRS) : 1;
  localparam int unsigned PAIR_CW  = $clog2(KERN_PAIRS + 1);

  localparam logic [1:0] CMD_GLYPH   = 2'd0;
  localparam logic [1:0] CMD_PAIR    = 2'd1;
  localparam logic [1:0] CMD_MEASURE = 2'd2;

  localparam logic [8:0] FALLBACK_CODE = 9'h1FF;

  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_ASPECT = 1'b1;

  localparam logic [15:0] CFG_RESET = 16'd256;

  localparam logic signed [20:0] WSUM_MAX = 21'sd524287;
  localparam logic signed [20:0] WSUM_MIN = -21'sd524288;

  typedef struct packed {
    logic [9:0] hgt;
    logic [9:0] adv;
  } glyph_t;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  amt;
  } pair_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_GLYPH = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_ADV   = 8'b0000_1000,
    ST_MUL1  = 8'b0001_0000,
    ST_MUL2  = 8'b0010_0000,
    ST_MUL3  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    PH_LOAD  = 3'b001,
    PH_KERN1 = 3'b010,
    PH_KERN2 = 3'b100
  } phase_e;

  function automatic logic signed [19:0] sat_add(logic signed [19:0] a,
                                                 logic signed [10:0] d);
    logic signed [20:0] s;
    s = 21'(a) + 21'(d);
    if (s > WSUM_MAX) begin
      s = WSUM_MAX;
    end else if (s < WSUM_MIN) begin
      s = WSUM_MIN;
    end
    return s[19:0];
  endfunction

endpackage

// ===== hdl/kerned_text_width_measure_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kerned text width measure core
// Holds glyph metrics and kerning pairs and measures byte strings.
//
// The input stream carries commands in s_axis_tuser: glyph loads, kerning
// pair loads and measured characters, one byte per transfer, with tlast on
// the final character. Each final character yields one output transfer with
// the scaled width and the scaled largest height; other commands yield none.
// A glyph load is written as it is taken. A pair load scans the pair memory,
// one entry a cycle. A character needs a pair scan when it follows another
// character of the string, and a final character adds a second scan and the
// multiply steps MUL1 to MUL3 before its result is registered. The pair memory
// read port paces the scans. Scale and aspect are written over the APB port at
// byte addresses 0 and 4 and reset to 1.0.
// Reset clears the glyph present bits, the fallback glyph, the pair count and
// the string state; memory contents are not cleared. When the receiver stalls
// the result waits in the output register while the next item is taken; a
// further result waits until that register is free.
// ----------------------------------------------------------------------------
module kerned_text_width_measure_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[8:0], second_code[16:9], advance[26:17], glyph_height[36:27],
  // kern_amount[44:37], zero fill above.
  input  logic [47:0] s_axis_tdata,
  // cmd[1:0].
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // text_width[15:0], text_height_q8[41:16], zero fill above.
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned GAW = kwm_pkg::GLYPH_AW;
  localparam int unsigned PAW = kwm_pkg::PAIR_AW;
  localparam int unsigned PCW = kwm_pkg::PAIR_CW;

  kwm_pkg::state_e state_q, state_d;
  kwm_pkg::phase_e phase_q, phase_d;

  logic [15:0] scale_q, aspect_q;

  logic [8:0]  in_code;
  logic [7:0]  in_second;
  logic [9:0]  in_adv;
  logic [9:0]  in_hgt;
  logic [7:0]  in_kamt;
  logic        s_accept;
  logic        code_in_range;
  logic        ch_in_range;

  kwm_pkg::glyph_t gmem [kwm_pkg::GLYPH_CODES];
  kwm_pkg::glyph_t g_rd_q;
  logic [kwm_pkg::GLYPH_CODES-1:0] present_q;
  logic        g_we;
  logic        g_re;
  logic [9:0]  fb_adv_q, fb_hgt_q;
  logic        fb_pres_q;
  logic        gp_q;

  kwm_pkg::pair_t pmem [kwm_pkg::KERN_PAIRS];
  kwm_pkg::pair_t p_rd_q;
  kwm_pkg::pair_t p_wdata;
  logic [PAW-1:0] p_waddr;
  logic        p_we;
  logic        p_re;

  logic [PCW-1:0] cnt_q, cnt_d;
  logic [PCW-1:0] idx_q, idx_d;
  logic           pend_q, pend_d;
  logic [PAW-1:0] pidx_q, pidx_d;
  logic           scan_hit;
  logic           scan_done;
  logic [10:0]    kern_ext;

  logic [7:0]  ch_q;
  logic        last_q;
  logic [15:0] key_q, key_d;
  logic [7:0]  kamt_q;
  logic [9:0]  sel_adv_q, sel_adv_d;
  logic [9:0]  sel_hgt_q, sel_hgt_d;

  logic signed [19:0] sum_q, sum_d;
  logic [9:0]  hmax_q, hmax_d;
  logic [7:0]  prev_q, prev_d;
  logic        in_str_q, in_str_d;

  logic [34:0] p1_q;
  logic [31:0] t_q;
  logic [35:0] w_q;
  logic [25:0] hprod;
  logic [15:0] w_sat;

  logic        out_load;
  logic        m_valid_q, m_valid_d;
  logic [15:0] m_width_q;
  logic [25:0] m_height_q;

  assign in_code   = s_axis_tdata[8:0];
  assign in_second = s_axis_tdata[16:9];
  assign in_adv    = s_axis_tdata[26:17];
  assign in_hgt    = s_axis_tdata[36:27];
  assign in_kamt   = s_axis_tdata[44:37];

  assign s_axis_tready = (state_q == kwm_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == kwm_pkg::REG_ASPECT) ? {16'd0, aspect_q} : {16'd0, scale_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= kwm_pkg::CFG_RESET;
      aspect_q <= kwm_pkg::CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == kwm_pkg::REG_ASPECT) begin
        aspect_q <= pwdata[15:0];
      end else begin
        scale_q <= pwdata[15:0];
      end
    end
  end

  // Glyph memory and present bits.
  assign code_in_range = !in_code[8] && ({1'b0, in_code} < 10'(kwm_pkg::GLYPH_CODES));
  assign ch_in_range   = ({2'b00, in_code[7:0]} < 10'(kwm_pkg::GLYPH_CODES));
  assign g_we = s_accept && (s_axis_tuser == kwm_pkg::CMD_GLYPH) && code_in_range;
  assign g_re = s_accept && (s_axis_tuser == kwm_pkg::CMD_MEASURE);

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[in_code[GAW-1:0]] <= '{hgt: in_hgt, adv: in_adv};
    end
    if (g_re) begin
      g_rd_q <= gmem[in_code[GAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      fb_pres_q <= 1'b0;
      fb_adv_q  <= '0;
      fb_hgt_q  <= '0;
    end else if (s_accept && (s_axis_tuser == kwm_pkg::CMD_GLYPH)) begin
      if (in_code == kwm_pkg::FALLBACK_CODE) begin
        fb_pres_q <= 1'b1;
        fb_adv_q  <= in_adv;
        fb_hgt_q  <= in_hgt;
      end else if (code_in_range) begin
        present_q[in_code[GAW-1:0]] <= 1'b1;
      end
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ch_q   <= in_code[7:0];
      last_q <= s_axis_tlast;
      kamt_q <= in_kamt;
      gp_q   <= ch_in_range && present_q[in_code[GAW-1:0]];
    end
  end

  // Pair memory.
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rd_q <= pmem[idx_q[PAW-1:0]];
    end
  end

  assign scan_hit  = pend_q && (p_rd_q.key == key_q);
  assign scan_done = scan_hit || (!pend_q && (idx_q >= cnt_q));
  assign p_re      = (state_q == kwm_pkg::ST_SCAN) && !scan_hit && (idx_q < cnt_q);
  assign kern_ext  = scan_hit ? {{3{p_rd_q.amt[7]}}, p_rd_q.amt} : 11'd0;

  assign hprod = hmax_q * scale_q;
  assign w_sat = (sum_q[19] || (sum_q == 20'sd0)) ? 16'd0 :
                 ((w_q > 36'd65535) ? 16'hFFFF : w_q[15:0]);
  assign out_load = (state_q == kwm_pkg::ST_FIN) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    key_d     = key_q;
    sel_adv_d = sel_adv_q;
    sel_hgt_d = sel_hgt_q;
    sum_d     = sum_q;
    hmax_d    = hmax_q;
    prev_d    = prev_q;
    in_str_d  = in_str_q;
    p_we      = 1'b0;
    p_waddr   = pidx_q;
    p_wdata   = '{key: key_q, amt: kamt_q};

    unique case (state_q)
      kwm_pkg::ST_IDLE: begin
        if (s_accept) begin
          if ((s_axis_tuser == kwm_pkg::CMD_PAIR) && !in_code[8]) begin
            key_d   = {in_code[7:0], in_second};
            phase_d = kwm_pkg::PH_LOAD;
            idx_d   = '0;
            pend_d  = 1'b0;
            state_d = kwm_pkg::ST_SCAN;
          end else if (s_axis_tuser == kwm_pkg::CMD_MEASURE) begin
            state_d = kwm_pkg::ST_GLYPH;
          end
        end
      end
      kwm_pkg::ST_GLYPH: begin
        if (gp_q) begin
          sel_adv_d = g_rd_q.adv;
          sel_hgt_d = g_rd_q.hgt;
        end else if (fb_pres_q) begin
          sel_adv_d = fb_adv_q;
          sel_hgt_d = fb_hgt_q;
        end else begin
          sel_adv_d = '0;
          sel_hgt_d = '0;
        end
        if (in_str_q) begin
          key_d   = {prev_q, ch_q};
          phase_d = kwm_pkg::PH_KERN1;
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = kwm_pkg::ST_SCAN;
        end else begin
          sum_d   = '0;
          hmax_d  = '0;
          state_d = kwm_pkg::ST_ADV;
        end
      end
      kwm_pkg::ST_SCAN: begin
        if (scan_done) begin
          pend_d = 1'b0;
          unique case (phase_q)
            kwm_pkg::PH_LOAD: begin
              if (scan_hit) begin
                p_we = 1'b1;
              end else if (cnt_q < PCW'(kwm_pkg::KERN_PAIRS)) begin
                p_we    = 1'b1;
                p_waddr = cnt_q[PAW-1:0];
                cnt_d   = cnt_q + 1'b1;
              end
              state_d = kwm_pkg::ST_IDLE;
            end
            kwm_pkg::PH_KERN1: begin
              sum_d   = kwm_pkg::sat_add(sum_q, kern_ext);
              state_d = kwm_pkg::ST_ADV;
            end
            kwm_pkg::PH_KERN2: begin
              sum_d   = kwm_pkg::sat_add(sum_q, kern_ext);
              state_d = kwm_pkg::ST_MUL1;
            end
            default: begin
              state_d = kwm_pkg::ST_IDLE;
            end
          endcase
        end else if (p_re) begin
          pend_d = 1'b1;
          pidx_d = idx_q[PAW-1:0];
          idx_d  = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      kwm_pkg::ST_ADV: begin
        sum_d    = kwm_pkg::sat_add(sum_q, $signed({1'b0, sel_adv_q}));
        hmax_d   = (sel_hgt_q > hmax_q) ? sel_hgt_q : hmax_q;
        prev_d   = ch_q;
        in_str_d = 1'b1;
        if (last_q) begin
          key_d   = {ch_q, 8'h00};
          phase_d = kwm_pkg::PH_KERN2;
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = kwm_pkg::ST_SCAN;
        end else begin
          state_d = kwm_pkg::ST_IDLE;
        end
      end
      kwm_pkg::ST_MUL1: begin
        state_d = kwm_pkg::ST_MUL2;
      end
      kwm_pkg::ST_MUL2: begin
        state_d = kwm_pkg::ST_MUL3;
      end
      kwm_pkg::ST_MUL3: begin
        state_d = kwm_pkg::ST_FIN;
      end
      kwm_pkg::ST_FIN: begin
        if (out_load) begin
          in_str_d = 1'b0;
          state_d  = kwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kwm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kwm_pkg::ST_IDLE;
      phase_q  <= kwm_pkg::PH_LOAD;
      cnt_q    <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      sum_q    <= '0;
      hmax_q   <= '0;
      prev_q   <= '0;
      in_str_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      sum_q    <= sum_d;
      hmax_q   <= hmax_d;
      prev_q   <= prev_d;
      in_str_q <= in_str_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    key_q     <= key_d;
    sel_adv_q <= sel_adv_d;
    sel_hgt_q <= sel_hgt_d;
  end

  // Width product: sum * scale, then split by 16 bits and times aspect.
  always_ff @(posedge clk_i) begin
    if (state_q == kwm_pkg::ST_MUL1) begin
      p1_q <= 35'(sum_q[18:0]) * 35'(scale_q);
    end
    if (state_q == kwm_pkg::ST_MUL2) begin
      t_q <= p1_q[15:0] * aspect_q;
    end
    if (state_q == kwm_pkg::ST_MUL3) begin
      w_q <= 36'(p1_q[34:16]) * 36'(aspect_q) + 36'(t_q[31:16]);
    end
  end

  // Output register.
  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_width_q  <= w_sat;
      m_height_q <= hprod;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_height_q, m_width_q};

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PCW'(kwm_pkg::KERN_PAIRS))
    else $error("pair count exceeds the pair memory depth");

  a_pend_below_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (PCW'(pidx_q) < cnt_q))
    else $error("pending pair read beyond the stored pairs");

  a_result_ends_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !in_str_q && m_valid_q)
    else $error("result transfer did not close the string");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kwm_pkg::ST_SCAN) |-> !s_accept && !out_load)
    else $error("item or result taken during a pair scan");
`endif

endmodule
